// ===== rtl/pssf_pkg.sv =====
// Shared constants and types for the polygon scanline span fill block.
package pssf_pkg;

  localparam int CoordW = 14;
  localparam int DimW   = 13;
  localparam int RowW   = 12;
  localparam int ProdW  = 28;

  typedef logic [1:0] op_t;

  localparam op_t OP_CLEAR  = 2'd0;
  localparam op_t OP_APPEND = 2'd1;
  localparam op_t OP_QUERY  = 2'd2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [DimW-1:0] dim_t;

endpackage

// ===== rtl/pssf_if.sv =====
// Valid/ready channel interfaces for command beats and span beats.
interface pssf_cmd_if;
  import pssf_pkg::*;
  logic   valid;
  logic   ready;
  op_t    operation;
  coord_t vertex_x;
  coord_t vertex_y;
  logic [RowW-1:0] row;
  modport source (output valid, operation, vertex_x, vertex_y, row, input ready);
  modport sink (input valid, operation, vertex_x, vertex_y, row, output ready);
endinterface

interface pssf_span_if;
  import pssf_pkg::*;
  logic   valid;
  logic   ready;
  dim_t   span_start;
  coord_t span_end;
  logic   has_span;
  logic   last;
  modport source (output valid, span_start, span_end, has_span, last, input ready);
  modport sink (input valid, span_start, span_end, has_span, last, output ready);
endinterface

// ===== rtl/polygon_scanline_span_fill_top.sv =====
// Top level of the even-odd scanline polygon span fill block.
// A row query walks every polygon edge with one shared multiplier and a one-bit-per-cycle
// divider; each crossing takes a 28-step division and then, while the crossing memory has
// room, an insertion into the sorted crossing memory. Spans then leave one after another,
// read through the single read port of the crossing memory. Out-of-range or empty rows give
// one empty last beat. Vertex and crossing memories need no clearing after reset.
module polygon_scanline_span_fill_top #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  pssf_cmd_if.sink             cmd,
  pssf_span_if.source          span,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import pssf_pkg::*;

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PREV  = 4'd1;
  localparam logic [3:0] S_PREVW = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_EDGE  = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;
  localparam logic [3:0] S_INS   = 4'd8;
  localparam logic [3:0] S_INSC  = 4'd9;
  localparam logic [3:0] S_E0    = 4'd10;
  localparam logic [3:0] S_E1    = 4'd11;
  localparam logic [3:0] S_E2    = 4'd12;
  localparam logic [3:0] S_EMPTY = 4'd13;

  dim_t screen_width;
  dim_t screen_height;

  logic [3:0]  state;
  logic [CW-1:0] vcnt;
  logic [CW-1:0] ei;
  logic [CW-1:0] xn;
  logic [CW-1:0] k;
  logic [CW-1:0] ea;
  logic [RowW-1:0] row_r;
  coord_t xi, xj, yj, xv, sa;
  logic [CoordW-1:0] dy_mag, dx_mag, den;
  logic qneg;
  logic [ProdW-1:0] dvd;
  logic [CoordW-1:0] rem;
  logic [4:0] dcnt;

  logic [2*CoordW-1:0] vmem [MAX_VERTICES];
  coord_t cmem [MAX_VERTICES];
  logic [2*CoordW-1:0] vrd;
  coord_t crd;
  logic [AW-1:0] vaddr, caddr, cwaddr;
  logic vwe, cwe;
  coord_t cwdata;

  logic   out_valid;
  dim_t   out_start;
  coord_t out_end;
  logic   out_has, out_last;
  logic   slot_free;
  logic   out_load;

  coord_t vx, vy;
  logic signed [CoordW:0] rs, yis, yjs, xis, xjs, dy, dx, dd, q15, x15, trial_s;
  logic [CoordW:0] trial;
  logic crossing;
  logic cmd_acc;
  coord_t wmax, e_cl;
  dim_t s_cl;
  logic pair_last;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HEIGHT) ? {{(32-DimW){1'b0}}, screen_height}
                                           : {{(32-DimW){1'b0}}, screen_width};

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= dim_t'(1920);
      screen_height <= dim_t'(1080);
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_HEIGHT) begin
        screen_height <= pwdata[DimW-1:0];
      end else begin
        screen_width <= pwdata[DimW-1:0];
      end
    end
  end

  assign cmd.ready = (state == S_IDLE);
  assign cmd_acc   = cmd.valid && cmd.ready;
  assign slot_free = !out_valid || span.ready;
  assign out_load  = slot_free && ((state == S_E2) || (state == S_EMPTY));

  assign span.valid      = out_valid;
  assign span.span_start = out_start;
  assign span.span_end   = out_end;
  assign span.has_span   = out_has;
  assign span.last       = out_last;

  assign vx  = vrd[2*CoordW-1:CoordW];
  assign vy  = vrd[CoordW-1:0];
  assign rs  = $signed({3'b000, row_r});
  assign yis = {vy[CoordW-1], vy};
  assign yjs = {yj[CoordW-1], yj};
  assign xis = {vx[CoordW-1], vx};
  assign xjs = {xj[CoordW-1], xj};
  assign dy  = rs - yis;
  assign dx  = xjs - xis;
  assign dd  = yjs - yis;
  assign crossing = ((yis < rs) && (yjs >= rs)) || ((yjs < rs) && (yis >= rs));

  assign trial   = {rem, dvd[ProdW-1]};
  assign trial_s = qneg ? -$signed({1'b0, dvd[CoordW-1:0]}) : $signed({1'b0, dvd[CoordW-1:0]});
  assign q15     = trial_s;
  assign x15     = {xi[CoordW-1], xi} + q15;

  assign wmax  = coord_t'($signed({1'b0, screen_width}) - 14'sd1);
  assign s_cl  = sa[CoordW-1] ? '0 : sa[DimW-1:0];
  assign e_cl  = (crd > wmax) ? wmax : crd;
  assign pair_last = ({1'b0, ea} + (CW+1)'(3)) >= {1'b0, xn};

  always_comb begin
    vaddr  = vcnt[AW-1:0];
    vwe    = 1'b0;
    caddr  = ea[AW-1:0];
    cwe    = 1'b0;
    cwaddr = k[AW-1:0];
    cwdata = xv;
    case (state)
      S_IDLE: begin
        vwe = cmd_acc && (cmd.operation == OP_APPEND) && (vcnt < CW'(MAX_VERTICES));
      end
      S_PREV: vaddr = AW'(vcnt - CW'(1));
      S_RD: vaddr = ei[AW-1:0];
      S_INS: begin
        caddr = AW'(k - CW'(1));
        cwe   = (k == '0);
      end
      S_INSC: begin
        cwe    = 1'b1;
        cwdata = (crd > xv) ? crd : xv;
      end
      S_E1, S_E2: caddr = AW'(ea + CW'(1));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (vwe) begin
      vmem[vaddr] <= {cmd.vertex_x, cmd.vertex_y};
    end
    vrd <= vmem[vaddr];
    if (cwe) begin
      cmem[cwaddr] <= cwdata;
    end
    crd <= cmem[caddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (span.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vcnt      <= '0;
      xn        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_acc) begin
            row_r <= cmd.row;
            case (cmd.operation)
              OP_CLEAR: vcnt <= '0;
              OP_APPEND: begin
                if (vcnt < CW'(MAX_VERTICES)) begin
                  vcnt <= vcnt + CW'(1);
                end
              end
              OP_QUERY: begin
                xn <= '0;
                ei <= '0;
                if (({1'b0, cmd.row} >= screen_height) || (vcnt == '0)) begin
                  state <= S_EMPTY;
                end else begin
                  state <= S_PREV;
                end
              end
              default: ;
            endcase
          end
        end
        S_PREV: state <= S_PREVW;
        S_PREVW: begin
          xj    <= vx;
          yj    <= vy;
          state <= S_RD;
        end
        S_RD: state <= S_EDGE;
        S_EDGE: begin
          xi <= vx;
          xj <= vx;
          yj <= vy;
          dy_mag <= dy[CoordW] ? CoordW'(-dy) : dy[CoordW-1:0];
          dx_mag <= dx[CoordW] ? CoordW'(-dx) : dx[CoordW-1:0];
          den    <= dd[CoordW] ? CoordW'(-dd) : dd[CoordW-1:0];
          qneg   <= dy[CoordW] ^ dx[CoordW] ^ dd[CoordW];
          if (crossing) begin
            state <= S_MUL;
          end else if (ei == vcnt - CW'(1)) begin
            ea    <= '0;
            state <= (xn < CW'(2)) ? S_EMPTY : S_E0;
          end else begin
            ei    <= ei + CW'(1);
            state <= S_RD;
          end
        end
        S_MUL: begin
          dvd   <= dy_mag * dx_mag;
          rem   <= '0;
          dcnt  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (trial >= {1'b0, den}) begin
            rem <= CoordW'(trial - {1'b0, den});
            dvd <= {dvd[ProdW-2:0], 1'b1};
          end else begin
            rem <= trial[CoordW-1:0];
            dvd <= {dvd[ProdW-2:0], 1'b0};
          end
          dcnt <= dcnt + 5'd1;
          if (dcnt == 5'(ProdW - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          xv <= x15[CoordW-1:0];
          k  <= xn;
          if (xn == CW'(MAX_VERTICES)) begin
            if (ei == vcnt - CW'(1)) begin
              ea    <= '0;
              state <= S_E0;
            end else begin
              ei    <= ei + CW'(1);
              state <= S_RD;
            end
          end else begin
            state <= S_INS;
          end
        end
        S_INS: begin
          if (k == '0) begin
            xn <= xn + CW'(1);
            if (ei == vcnt - CW'(1)) begin
              ea    <= '0;
              state <= ((xn + CW'(1)) < CW'(2)) ? S_EMPTY : S_E0;
            end else begin
              ei    <= ei + CW'(1);
              state <= S_RD;
            end
          end else begin
            state <= S_INSC;
          end
        end
        S_INSC: begin
          if (crd > xv) begin
            k     <= k - CW'(1);
            state <= S_INS;
          end else begin
            xn <= xn + CW'(1);
            if (ei == vcnt - CW'(1)) begin
              ea    <= '0;
              state <= ((xn + CW'(1)) < CW'(2)) ? S_EMPTY : S_E0;
            end else begin
              ei    <= ei + CW'(1);
              state <= S_RD;
            end
          end
        end
        S_E0: state <= S_E1;
        S_E1: begin
          sa    <= crd;
          state <= S_E2;
        end
        S_E2: begin
          if (slot_free) begin
            out_start <= s_cl;
            out_end   <= e_cl;
            out_has   <= 1'b1;
            out_last  <= pair_last;
            ea        <= ea + CW'(2);
            state     <= pair_last ? S_IDLE : S_E0;
          end
        end
        S_EMPTY: begin
          if (slot_free) begin
            out_start <= '0;
            out_end   <= '0;
            out_has   <= 1'b0;
            out_last  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_vcnt_cap: assert property (@(posedge clk) disable iff (rst)
    vcnt <= CW'(MAX_VERTICES)) else $error("vertex count above capacity");
  a_xn_edges: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (xn <= vcnt)) else $error("more crossings than edges");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (cmd_acc && (cmd.operation == OP_CLEAR)) |=> (vcnt == '0)) else $error("clear failed");
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_has) |-> out_last) else $error("empty beat not last");
`endif

endmodule
